// ===== sv/assert_macros.svh =====
// Shared assertion macros for the comment stripper RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check prop at every clock edge outside of reset.
`define JCS_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("jcs assertion failed");

// Check prop at every clock edge, reset included.
`define JCS_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("jcs assertion failed");

`endif

// ===== sv/jcs_pkg.sv =====
package jcs_pkg;

    localparam int unsigned JCS_QUEUE_DEPTH = 4;

    localparam logic [7:0] CH_STAR      = 8'h2A;
    localparam logic [7:0] CH_SLASH     = 8'h2F;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_U         = 8'h75;
    localparam logic [7:0] CH_CR        = 8'h0D;
    localparam logic [7:0] CH_LF        = 8'h0A;

    // One classified byte: a held slash to flush first, and/or the byte itself.
    typedef struct packed {
        logic       slash;
        logic       emit;
        logic [7:0] data;
    } jcs_cmd_t;

endpackage

// ===== sv/jcs_front.sv =====
`include "assert_macros.svh"

module jcs_front
    import jcs_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     in_valid,
    input  logic     in_ready,
    input  logic [7:0] in_byte,
    output logic     push,
    output jcs_cmd_t push_cmd
);

    typedef enum logic [2:0] {
        PH_NONE       = 3'd0,
        PH_SLASH      = 3'd1,
        PH_BLOCK      = 3'd2,
        PH_BLOCK_STAR = 3'd3,
        PH_LINE       = 3'd4
    } phase_t;

    typedef enum logic [2:0] {
        ESC_NONE = 3'd0,
        ESC_BACK = 3'd1,
        ESC_H1   = 3'd2,
        ESC_H2   = 3'd3,
        ESC_H3   = 3'd4
    } esc_t;

    phase_t phase_reg, phase_next;
    esc_t   esc_reg, esc_next;
    logic   str_reg, str_next;
    logic   held;
    logic   consumed;
    logic   skip_a;
    logic   skip_b;
    logic   emit;
    logic   accept;

    assign accept = in_valid && in_ready;

    always_comb begin
        phase_next = phase_reg;
        esc_next   = esc_reg;
        str_next   = str_reg;
        held       = 1'b0;
        consumed   = 1'b0;

        if (esc_reg == ESC_NONE) begin
            unique case (phase_reg)
                PH_SLASH: begin
                    if (in_byte == CH_STAR) begin
                        phase_next = PH_BLOCK;
                    end else if (in_byte == CH_SLASH) begin
                        phase_next = PH_LINE;
                    end else begin
                        phase_next = PH_NONE;
                        held       = 1'b1;
                    end
                end
                PH_BLOCK: begin
                    if (in_byte == CH_STAR) phase_next = PH_BLOCK_STAR;
                end
                PH_BLOCK_STAR: begin
                    if (in_byte == CH_SLASH) begin
                        phase_next = PH_NONE;
                        consumed   = 1'b1;
                    end else if (in_byte != CH_STAR) begin
                        phase_next = PH_BLOCK;
                    end
                end
                PH_LINE: begin
                    if (in_byte == CH_CR || in_byte == CH_LF) phase_next = PH_NONE;
                end
                default: ;
            endcase
        end

        skip_a = (phase_next >= PH_SLASH) && (phase_next <= PH_LINE);

        if (!consumed && !skip_a) begin
            unique case (esc_reg)
                ESC_NONE: begin
                    if (in_byte == CH_BACKSLASH) begin
                        esc_next = ESC_BACK;
                    end else if (in_byte == CH_QUOTE) begin
                        str_next = !str_reg;
                    end else if (!str_reg && in_byte == CH_SLASH) begin
                        phase_next = PH_SLASH;
                    end
                end
                ESC_BACK: esc_next = (in_byte == CH_U) ? ESC_H1 : ESC_NONE;
                ESC_H1:   esc_next = ESC_H2;
                ESC_H2:   esc_next = ESC_H3;
                default:  esc_next = ESC_NONE;
            endcase
        end

        skip_b = (phase_next >= PH_SLASH) && (phase_next <= PH_LINE);
        emit   = !consumed && !skip_b;
    end

    assign push          = accept && (held || emit);
    assign push_cmd.slash = held;
    assign push_cmd.emit  = emit;
    assign push_cmd.data  = in_byte;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_NONE;
            esc_reg   <= ESC_NONE;
            str_reg   <= 1'b0;
        end else if (accept) begin
            phase_reg <= phase_next;
            esc_reg   <= esc_next;
            str_reg   <= str_next;
        end
    end

    // escapes only start with no comment pending, and comments only open unescaped
    `JCS_ASSERT(a_esc_no_comment, aclk, aresetn, (esc_reg != ESC_NONE) |-> (phase_reg == PH_NONE))
    `JCS_ASSERT(a_phase_legal, aclk, aresetn, phase_reg <= PH_LINE)

endmodule

// ===== sv/jcs_queue.sv =====
`include "assert_macros.svh"

module jcs_queue
    import jcs_pkg::*;
#(
    parameter int unsigned DEPTH = JCS_QUEUE_DEPTH
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     push,
    input  jcs_cmd_t push_cmd,
    output logic     not_full,
    input  logic     pop,
    output logic     not_empty,
    output jcs_cmd_t head
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    jcs_cmd_t         mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign not_full  = (count_reg != FULL_CNT);
    assign not_empty = (count_reg != '0);
    assign head      = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)  rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop) count_next = count_reg + 1'b1;
        else if (!push && pop) count_next = count_reg - 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) mem[wr_ptr_reg] <= push_cmd;
    end

    `JCS_ASSERT(a_no_overflow, aclk, aresetn, push |-> (not_full || pop))
    `JCS_ASSERT(a_no_underflow, aclk, aresetn, pop |-> not_empty)

endmodule

// ===== sv/jcs_back.sv =====
`include "assert_macros.svh"

module jcs_back
    import jcs_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       head_valid,
    input  jcs_cmd_t   head,
    output logic       pop,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,
    output logic       m_tlast
);

    logic       valid_reg, valid_next;
    logic [7:0] data_reg, data_next;
    logic       last_reg, last_next;
    logic       slash_done_reg, slash_done_next;
    logic       load;

    assign load = head_valid && (!valid_reg || m_tready);

    always_comb begin
        valid_next      = valid_reg && !m_tready;
        data_next       = data_reg;
        last_next       = last_reg;
        slash_done_next = slash_done_reg;
        pop             = 1'b0;
        if (load) begin
            valid_next = 1'b1;
            if (head.slash && !slash_done_reg) begin
                // flush the held slash; hold the entry if its byte still follows
                data_next = CH_SLASH;
                last_next = !head.emit;
                if (head.emit) slash_done_next = 1'b1;
                else           pop = 1'b1;
            end else begin
                data_next       = head.data;
                last_next       = 1'b1;
                slash_done_next = 1'b0;
                pop             = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg      <= 1'b0;
            slash_done_reg <= 1'b0;
        end else begin
            valid_reg      <= valid_next;
            slash_done_reg <= slash_done_next;
        end
        data_reg <= data_next;
        last_reg <= last_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tlast  = last_reg;

    `JCS_ASSERT(a_split_first_half, aclk, aresetn,
        $rose(slash_done_reg) |-> (valid_reg && data_reg == CH_SLASH && !last_reg))
    `JCS_ASSERT_ALWAYS(a_reset_idle, aclk, !aresetn |=> (!valid_reg && !slash_done_reg))

endmodule

// ===== sv/jsonc_comment_stripper_core.sv =====
// A byte's first result passes through the queue and then the output register before it is valid on m_tvalid.
// Throughput: one byte per cycle while the queue is not full; a byte that flushes a held slash is sent
// as two output bytes, and the queue between classifier and output stage absorbs that and m_tready stalls.
// Skipped comment bytes produce no output but are still taken from the input like any other byte.
// Reset (aresetn low, synchronous): comment, escape and string state clear, queue empties,
// m_tvalid drops. A slash still held when the stream ends is never emitted.
module jsonc_comment_stripper_core
    import jcs_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = JCS_QUEUE_DEPTH
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_byte
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic       m_tlast
);

    logic     push;
    jcs_cmd_t push_cmd;
    logic     not_full;
    logic     pop;
    logic     not_empty;
    jcs_cmd_t head;

    assign s_tready = not_full;

    jcs_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_byte  (s_tdata),
        .push     (push),
        .push_cmd (push_cmd)
    );

    jcs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_cmd  (push_cmd),
        .not_full  (not_full),
        .pop       (pop),
        .not_empty (not_empty),
        .head      (head)
    );

    jcs_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (not_empty),
        .head       (head),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

endmodule

// ===== tb/sv/jcs_stream_checker.sv =====
`timescale 1ns / 100ps

module jcs_stream_checker
    import jcs_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    input  logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_byte
    input  logic       m_tvalid,
    input  logic       m_tready,
    input  logic [7:0] m_tdata,   // [7:0] out_byte
    input  logic       m_tlast,
    output int         fail_count,
    output int         queued
);

    typedef enum logic [2:0] {
        CPH_TEXT,
        CPH_SLASH,
        CPH_BLOCK,
        CPH_BLOCK_STAR,
        CPH_LINE
    } cphase_t;

    typedef enum logic [2:0] {
        ESC_NONE,
        ESC_BACK,
        ESC_HEX1,
        ESC_HEX2,
        ESC_HEX3
    } esc_t;

    typedef struct packed {
        logic [7:0] data;
        logic       tlast;
    } stripped_t;

    stripped_t plain_q[$];
    cphase_t   cph = CPH_TEXT;
    esc_t      esc = ESC_NONE;
    logic      in_str = 1'b0;

    initial begin
        fail_count = 0;
        queued     = 0;
    end

    task automatic report(input string msg);
        $display("[%0t] MISMATCH: %s", $time, msg);
        fail_count++;
    endtask

    // Advance the stripper state by one request and queue the bytes it lets through.
    function automatic void strip_byte(input logic [7:0] ch);
        logic held = 1'b0;
        logic eaten = 1'b0;
        logic skip;
        if (esc == ESC_NONE) begin
            case (cph)
                CPH_SLASH: begin
                    if (ch == CH_STAR) cph = CPH_BLOCK;
                    else if (ch == CH_SLASH) cph = CPH_LINE;
                    else begin
                        cph  = CPH_TEXT;
                        held = 1'b1;
                    end
                end
                CPH_BLOCK: if (ch == CH_STAR) cph = CPH_BLOCK_STAR;
                CPH_BLOCK_STAR: begin
                    if (ch == CH_SLASH) begin
                        cph   = CPH_TEXT;
                        eaten = 1'b1;
                    end else if (ch != CH_STAR) begin
                        cph = CPH_BLOCK;
                    end
                end
                CPH_LINE: if (ch == CH_CR || ch == CH_LF) cph = CPH_TEXT;
                default: ;
            endcase
        end
        if (held) plain_q.push_back('{data: CH_SLASH, tlast: 1'b0});
        if (eaten) return;
        skip = (cph != CPH_TEXT);
        if (!skip) begin
            case (esc)
                ESC_NONE: begin
                    if (ch == CH_BACKSLASH) esc = ESC_BACK;
                    else if (ch == CH_QUOTE) in_str = ~in_str;
                    else if (!in_str && ch == CH_SLASH) cph = CPH_SLASH;
                end
                ESC_BACK: esc = (ch == CH_U) ? ESC_HEX1 : ESC_NONE;
                ESC_HEX1: esc = ESC_HEX2;
                ESC_HEX2: esc = ESC_HEX3;
                default:  esc = ESC_NONE;
            endcase
            skip = (cph != CPH_TEXT);
        end
        if (!skip) plain_q.push_back('{data: ch, tlast: 1'b1});
        else if (held) plain_q[plain_q.size() - 1].tlast = 1'b1;
    endfunction

    always @(posedge aclk) begin : watch
        stripped_t want;
        if (!aresetn) begin
            cph    = CPH_TEXT;
            esc    = ESC_NONE;
            in_str = 1'b0;
            plain_q.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (plain_q.size() == 0) begin
                    report($sformatf("unexpected byte %02h last %0b", m_tdata, m_tlast));
                end else begin
                    want = plain_q.pop_front();
                    if (m_tdata !== want.data)
                        report($sformatf("out_byte %02h, want %02h", m_tdata, want.data));
                    if (m_tlast !== want.tlast)
                        report($sformatf("last_of_run %0b on byte %02h, want %0b",
                                         m_tlast, m_tdata, want.tlast));
                end
            end
            if (s_tvalid && s_tready) strip_byte(s_tdata);
        end
        queued = plain_q.size();
    end

endmodule

// ===== tb/sv/tb_jsonc_comment_stripper_core.sv =====
`timescale 1ns / 100ps

module tb_jsonc_comment_stripper_core;
    import jcs_pkg::*;

    localparam int RAND_BYTES  = 1600;
    localparam int QUIET_LIMIT = 1000;
    localparam int TAIL_CYCLES = 12;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata = 8'h00;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic       m_tlast;

    int          n_fail;
    int          n_queued;
    int          quiet = 0;
    int unsigned ready_hold = 0;
    logic        calm = 1'b0;
    logic [7:0]  raw_text[$];

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    jsonc_comment_stripper_core u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    jcs_stream_checker u_check (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .fail_count (n_fail),
        .queued     (n_queued)
    );

    // Hold m_tready for random stretches: mostly ready, short stalls, a rare long one.
    always @(posedge aclk) begin
        int unsigned r;
        if (!aresetn) begin
            m_tready   <= 1'b0;
            ready_hold <= 0;
        end else if (ready_hold != 0) begin
            ready_hold <= ready_hold - 1;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
                m_tready   <= 1'b1;
                ready_hold <= $urandom_range(0, 19);
            end else if (r < 90) begin
                m_tready   <= 1'b0;
                ready_hold <= $urandom_range(0, 2);
            end else if (r < 97) begin
                m_tready   <= 1'b0;
                ready_hold <= $urandom_range(3, 11);
            end else begin
                m_tready   <= 1'b0;
                ready_hold <= $urandom_range(19, 39);
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            quiet <= 0;
        end else if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet <= 0;
        end else if (quiet >= QUIET_LIMIT) begin
            $display("watchdog: no request moved for %0d cycles", quiet);
            $display("TEST FAILED");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic logic [7:0] pick_special();
        case ($urandom_range(0, 6))
            0:       return CH_STAR;
            1:       return CH_SLASH;
            2:       return CH_BACKSLASH;
            3:       return CH_QUOTE;
            4:       return CH_U;
            5:       return CH_CR;
            default: return CH_LF;
        endcase
    endfunction

    // Mostly printable text with special bytes mixed in, now and then any byte.
    function automatic logic [7:0] pick_body();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 2) return pick_special();
        if (r < 3) return 8'($urandom_range(0, 255));
        return 8'($urandom_range(8'h20, 8'h7E));
    endfunction

    function automatic void push_text(input string s);
        for (int i = 0; i < s.len(); i++) raw_text.push_back(s[i]);
    endfunction

    function automatic void add_token();
        int unsigned n;
        n = $urandom_range(0, 6);
        case ($urandom_range(0, 9))
            0, 1: begin
                for (int i = 0; i <= n; i++) raw_text.push_back(8'($urandom_range(0, 255)));
            end
            2: begin
                raw_text.push_back(CH_SLASH);
                raw_text.push_back(CH_STAR);
                for (int i = 0; i < n; i++) raw_text.push_back(pick_body());
                repeat ($urandom_range(1, 3)) raw_text.push_back(CH_STAR);
                raw_text.push_back(CH_SLASH);
            end
            3: begin
                raw_text.push_back(CH_SLASH);
                raw_text.push_back(CH_SLASH);
                for (int i = 0; i < n; i++) raw_text.push_back(pick_body());
                raw_text.push_back($urandom_range(0, 1) ? CH_CR : CH_LF);
            end
            4: begin
                raw_text.push_back(CH_QUOTE);
                for (int i = 0; i < n; i++) begin
                    if ($urandom_range(0, 3) == 0) raw_text.push_back(CH_BACKSLASH);
                    raw_text.push_back(pick_body());
                end
                raw_text.push_back(CH_QUOTE);
            end
            5: begin
                raw_text.push_back(CH_BACKSLASH);
                raw_text.push_back(CH_U);
                repeat (4) begin
                    if ($urandom_range(0, 2) == 0) raw_text.push_back(pick_special());
                    else raw_text.push_back(8'($urandom_range(8'h30, 8'h39)));
                end
            end
            6: begin
                raw_text.push_back(CH_SLASH);
                raw_text.push_back(8'($urandom_range(0, 255)));
            end
            7: begin
                raw_text.push_back(CH_BACKSLASH);
                raw_text.push_back(pick_special());
            end
            8: begin
                for (int i = 0; i <= n; i++) raw_text.push_back(pick_special());
            end
            default: begin
                push_text("{");
                raw_text.push_back(CH_QUOTE);
                push_text("k");
                raw_text.push_back(CH_QUOTE);
                push_text(":1}");
            end
        endcase
    endfunction

    task automatic send_byte(input logic [7:0] b);
        int unsigned gap;
        gap = pick_gap();
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: byte extremes, held slash, block close with a star run,
        // line comments ended by LF and CR, slash and escaped quote inside a string,
        // slashes swallowed by a unicode escape, then the fourth digit opening a slash.
        raw_text.push_back(8'h00);
        raw_text.push_back(8'hFF);
        raw_text.push_back(CH_SLASH);
        push_text("a");
        raw_text.push_back(CH_SLASH);
        raw_text.push_back(CH_STAR);
        push_text("x");
        raw_text.push_back(CH_STAR);
        raw_text.push_back(CH_STAR);
        raw_text.push_back(CH_SLASH);
        raw_text.push_back(CH_SLASH);
        raw_text.push_back(CH_SLASH);
        push_text("q");
        raw_text.push_back(CH_LF);
        raw_text.push_back(CH_SLASH);
        raw_text.push_back(CH_SLASH);
        raw_text.push_back(CH_CR);
        raw_text.push_back(CH_QUOTE);
        raw_text.push_back(CH_SLASH);
        raw_text.push_back(CH_BACKSLASH);
        raw_text.push_back(CH_QUOTE);
        raw_text.push_back(CH_QUOTE);
        raw_text.push_back(CH_BACKSLASH);
        raw_text.push_back(CH_U);
        repeat (4) raw_text.push_back(CH_SLASH);
        push_text("b");

        while (raw_text.size() < RAND_BYTES) add_token();
        // End on a slash that stays held if the stream is then outside a string and a comment.
        raw_text.push_back(CH_QUOTE);
        raw_text.push_back(CH_QUOTE);
        raw_text.push_back(CH_SLASH);

        foreach (raw_text[i]) begin
            if ($urandom_range(0, 63) == 0) calm = ~calm;
            send_byte(raw_text[i]);
        end
        s_tvalid <= 1'b0;

        while (n_queued != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (n_fail == 0 && n_queued == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("%0d mismatches, %0d bytes still owed", n_fail, n_queued);
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
